@@ rtl/pipe_separated_header_parser_core_macros.svh @@
// Assertion macros for the header parser core.
// Used by the top level only; no other dependencies.
`ifndef PIPE_SEPARATED_HEADER_PARSER_CORE_MACROS_SVH
`define PIPE_SEPARATED_HEADER_PARSER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Combinational property checked at every edge outside reset.
`define PHC_ASSERT(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("phc assertion failed");
// Implication from one cycle into the next.
`define PHC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("phc sequence assertion failed");
`else
`define PHC_ASSERT(lbl, clk, rstn, expr)
`define PHC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ rtl/phc_pkg.sv @@
// Types, character codes and result kinds for the header parser core.
// No dependencies.
`timescale 1ns / 1ps

package phc_pkg;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_PIPE  = 8'h7C;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam int SIZE_W = 64;
    localparam int CK_W   = 32;

    typedef enum logic [2:0] {
        KIND_CLIENT_CHAR = 3'd0,
        KIND_CLIENT_END  = 3'd1,
        KIND_FILE_CHAR   = 3'd2,
        KIND_FILE_END    = 3'd3,
        KIND_DONE        = 3'd4,
        KIND_MALFORMED   = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        FIELD_CLIENT = 2'd0,
        FIELD_FILE   = 2'd1,
        FIELD_SIZE   = 2'd2,
        FIELD_CK     = 2'd3
    } t_field;

    typedef enum logic [1:0] {
        PHASE_SKIP   = 2'd0,
        PHASE_SIGN   = 2'd1,
        PHASE_DIGITS = 2'd2,
        PHASE_STOP   = 2'd3
    } t_phase;

    // Outcome of one byte in a decimal field.
    typedef struct packed {
        t_phase     phase;
        logic       neg;
        logic       take;
        logic [3:0] digit;
    } t_num_res;

    // One parser result, before the output register.
    typedef struct packed {
        logic                     valid;
        t_kind                    kind;
        logic [7:0]               char_value;
        logic signed [SIZE_W-1:0] hdr_size;
        logic [CK_W-1:0]          hdr_cksum;
    } t_result;

endpackage

@@ rtl/phc_num_step.sv @@
// Per-byte step of the atol-style decimal scan: whitespace, sign, digits.
// Depends on phc_pkg.
`timescale 1ns / 1ps

module phc_num_step (
    input  logic [7:0]        i_byte,
    input  phc_pkg::t_phase   i_phase,
    input  logic              i_neg,
    output phc_pkg::t_num_res o_res
);

    logic is_digit;
    logic is_space;

    assign is_digit = (i_byte >= phc_pkg::CHAR_ZERO) && (i_byte <= phc_pkg::CHAR_NINE);
    assign is_space = (i_byte == phc_pkg::CHAR_SPACE) ||
                      ((i_byte >= phc_pkg::CHAR_TAB) && (i_byte <= phc_pkg::CHAR_CR));

    always_comb begin
        o_res.phase = i_phase;
        o_res.neg   = i_neg;
        o_res.take  = 1'b0;
        o_res.digit = i_byte[3:0];
        if ((i_phase == phc_pkg::PHASE_SKIP) && is_space) begin
            // stay in whitespace skip
        end else if ((i_phase == phc_pkg::PHASE_SKIP) &&
                     ((i_byte == phc_pkg::CHAR_PLUS) || (i_byte == phc_pkg::CHAR_MINUS))) begin
            o_res.neg   = (i_byte == phc_pkg::CHAR_MINUS);
            o_res.phase = phc_pkg::PHASE_SIGN;
        end else if (i_phase == phc_pkg::PHASE_STOP) begin
            // parse already ended, byte ignored
        end else if (is_digit) begin
            o_res.phase = phc_pkg::PHASE_DIGITS;
            o_res.take  = 1'b1;
        end else begin
            o_res.phase = phc_pkg::PHASE_STOP;
        end
    end

endmodule

@@ rtl/phc_parser.sv @@
// Field state and accumulators of the header parser; forms at most one result per byte.
// Depends on phc_pkg and phc_num_step.
`timescale 1ns / 1ps

module phc_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_byte,
    output phc_pkg::t_result o_res
);

    phc_pkg::t_field             r_field, n_field;
    phc_pkg::t_phase             r_phase, n_phase;
    logic                        r_neg, n_neg;
    logic [phc_pkg::SIZE_W-1:0]  r_size, n_size;
    logic [phc_pkg::CK_W-1:0]    r_ck, n_ck;

    phc_pkg::t_num_res num;
    logic [phc_pkg::SIZE_W-1:0]  size_mac;
    logic [phc_pkg::CK_W-1:0]    ck_mac;

    phc_num_step u_num (
        .i_byte  (i_byte),
        .i_phase (r_phase),
        .i_neg   (r_neg),
        .o_res   (num)
    );

    // x*10 + d as shift-add
    assign size_mac = {r_size[phc_pkg::SIZE_W-4:0], 3'b000} +
                      {r_size[phc_pkg::SIZE_W-2:0], 1'b0} +
                      {{(phc_pkg::SIZE_W-4){1'b0}}, num.digit};
    assign ck_mac   = {r_ck[phc_pkg::CK_W-4:0], 3'b000} +
                      {r_ck[phc_pkg::CK_W-2:0], 1'b0} +
                      {{(phc_pkg::CK_W-4){1'b0}}, num.digit};

    always_comb begin
        n_field = r_field;
        n_phase = r_phase;
        n_neg   = r_neg;
        n_size  = r_size;
        n_ck    = r_ck;
        o_res.valid         = 1'b0;
        o_res.kind          = phc_pkg::KIND_MALFORMED;
        o_res.char_value    = 8'h00;
        o_res.hdr_size      = '0;
        o_res.hdr_cksum     = '0;
        case (r_field)
            phc_pkg::FIELD_CLIENT, phc_pkg::FIELD_FILE: begin
                o_res.valid = 1'b1;
                if (i_byte == phc_pkg::CHAR_NUL) begin
                    n_field = phc_pkg::FIELD_CLIENT;
                    n_phase = phc_pkg::PHASE_SKIP;
                    n_neg   = 1'b0;
                    n_size  = '0;
                    n_ck    = '0;
                    o_res.kind = phc_pkg::KIND_MALFORMED;
                end else if (i_byte == phc_pkg::CHAR_PIPE) begin
                    n_phase = phc_pkg::PHASE_SKIP;
                    n_neg   = 1'b0;
                    if (r_field == phc_pkg::FIELD_CLIENT) begin
                        n_field    = phc_pkg::FIELD_FILE;
                        o_res.kind = phc_pkg::KIND_CLIENT_END;
                    end else begin
                        n_field    = phc_pkg::FIELD_SIZE;
                        o_res.kind = phc_pkg::KIND_FILE_END;
                    end
                end else begin
                    o_res.char_value = i_byte;
                    o_res.kind = (r_field == phc_pkg::FIELD_CLIENT) ?
                                 phc_pkg::KIND_CLIENT_CHAR : phc_pkg::KIND_FILE_CHAR;
                end
            end
            phc_pkg::FIELD_SIZE: begin
                if (i_byte == phc_pkg::CHAR_NUL) begin
                    o_res.valid = 1'b1;
                    o_res.kind  = phc_pkg::KIND_MALFORMED;
                    n_field = phc_pkg::FIELD_CLIENT;
                    n_phase = phc_pkg::PHASE_SKIP;
                    n_neg   = 1'b0;
                    n_size  = '0;
                    n_ck    = '0;
                end else if (i_byte == phc_pkg::CHAR_PIPE) begin
                    if (r_neg) begin
                        n_size = '0 - r_size;
                    end
                    n_field = phc_pkg::FIELD_CK;
                    n_phase = phc_pkg::PHASE_SKIP;
                    n_neg   = 1'b0;
                    n_ck    = '0;
                end else begin
                    n_phase = num.phase;
                    n_neg   = num.neg;
                    if (num.take) begin
                        n_size = size_mac;
                    end
                end
            end
            default: begin
                // checksum field; a pipe here is just a non-digit
                if (i_byte == phc_pkg::CHAR_NUL) begin
                    o_res.valid     = 1'b1;
                    o_res.kind      = phc_pkg::KIND_DONE;
                    o_res.hdr_size  = r_size;
                    o_res.hdr_cksum = r_neg ? ('0 - r_ck) : r_ck;
                    n_field = phc_pkg::FIELD_CLIENT;
                    n_phase = phc_pkg::PHASE_SKIP;
                    n_neg   = 1'b0;
                    n_size  = '0;
                    n_ck    = '0;
                end else begin
                    n_phase = num.phase;
                    n_neg   = num.neg;
                    if (num.take) begin
                        n_ck = ck_mac;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field <= phc_pkg::FIELD_CLIENT;
            r_phase <= phc_pkg::PHASE_SKIP;
            r_neg   <= 1'b0;
            r_size  <= '0;
            r_ck    <= '0;
        end else if (i_fire) begin
            r_field <= n_field;
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_size  <= n_size;
            r_ck    <= n_ck;
        end
    end

endmodule

@@ rtl/pipe_separated_header_parser_core.sv @@
// Top level of the pipe-separated header parser: input register, parser, result register.
// Depends on phc_pkg, phc_parser and the assertion macro header.
//
// channel  dir  tdata                                   tuser
// s_axis   in   [7:0] byte_value                         -
// m_axis   out  [7:0] char, [71:8] size, [103:72] cksum  [2:0] kind
//
// One byte per cycle sustained while results are accepted; each byte passes through
// the input register and then the result register.
// Size and checksum bytes produce no result, but a NUL there does; every other byte produces one.
// Reset is synchronous, active low, and returns the parser to the client field.
// A stalled result holds; the input register keeps filling until it is also full.
`timescale 1ns / 1ps
`include "pipe_separated_header_parser_core_macros.svh"

module pipe_separated_header_parser_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,   // [7:0] byte_value
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [103:0] o_m_tdata,   // [7:0] char_value, [71:8] hdr_size,
                                      // [103:72] hdr_cksum
    output logic [2:0]   o_m_tuser    // [2:0] kind
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    phc_pkg::t_result  r_out;
    phc_pkg::t_result  res;
    logic              advance;
    logic              out_is_char;
    logic              out_nums_zero;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || (!r_out_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    phc_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res.valid;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res.valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tdata  = {r_out.hdr_cksum, r_out.hdr_size, r_out.char_value};

    assign out_is_char   = (r_out.kind == phc_pkg::KIND_CLIENT_CHAR) ||
                           (r_out.kind == phc_pkg::KIND_FILE_CHAR);
    assign out_nums_zero = (r_out.hdr_size == '0) && (r_out.hdr_cksum == '0);

    // Only character kinds carry a character.
    `PHC_ASSERT(a_char_only_for_chars, i_clk, i_rst_n, !r_out_valid || r_out.char_value == 8'h00 || out_is_char)
    // Numbers are zero except on a done result.
    `PHC_ASSERT(a_numbers_only_on_done, i_clk, i_rst_n, !r_out_valid || r_out.kind == phc_pkg::KIND_DONE || out_nums_zero)
    // Both stages full and downstream stalled: no new request taken.
    `PHC_ASSERT(a_backpressure, i_clk, i_rst_n, !(r_in_valid && r_out_valid && !i_m_tready) || !o_s_tready)
    // A stalled byte in the input register stays there.
    `PHC_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !advance, r_in_valid && $stable(r_in_byte))

endmodule
